>>> rtl/core/mkds_pkg.sv
// Package for the debouncing keypad scanner: sizes, register indexes and
// reset values shared by the lane, merge and top-level modules.
// No dependencies.
`timescale 1ns / 1ps

package mkds_pkg;

  // Default keypad geometry
  localparam int unsigned ROWS_DEF = 4;
  localparam int unsigned COLS_DEF = 4;

  // Column levels carried by one item
  localparam int unsigned SAMPLE_W = 4;

  // Field widths
  localparam int unsigned ROW_IDX_W = 2;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  // Most events one item may emit
  localparam int unsigned MAX_EVENTS = 4;
  localparam int unsigned EV_CNT_W   = $clog2(MAX_EVENTS);

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT     = 2'd1;

  localparam logic [CNT_W-1:0] PRESS_THRESHOLD_RST = 8'd3;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST     = 8'd250;

endpackage

>>> rtl/core/mkds_lane.sv
// One column lane of the keypad scanner: the held counters of one column,
// one per row, with the saturating update and threshold compare.
// Depends on mkds_pkg.
`timescale 1ns / 1ps

module mkds_lane #(
  parameter int unsigned ROWS = mkds_pkg::ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_i,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] row_i,
  input  logic                            high_i,
  input  logic [mkds_pkg::CNT_W-1:0]      threshold_i,
  input  logic [mkds_pkg::CNT_W-1:0]      limit_i,
  output logic                            hit_o
);

  logic [mkds_pkg::CNT_W-1:0] cnt_q [ROWS];
  logic [mkds_pkg::CNT_W-1:0] cnt_cur;
  logic [mkds_pkg::CNT_W-1:0] cnt_d;

  // Count up while high, stop at the limit, clear when low
  always_comb begin
    cnt_cur = cnt_q[row_i];
    if (high_i) begin
      if (cnt_cur < limit_i) begin
        cnt_d = cnt_cur + 8'd1;
      end else begin
        cnt_d = cnt_cur;
      end
    end else begin
      cnt_d = '0;
    end
  end

  assign hit_o = upd_i && (cnt_d == threshold_i);

  // Hold the counters; write back the driven row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        cnt_q[r] <= '0;
      end
    end else if (upd_i) begin
      cnt_q[row_i] <= cnt_d;
    end
  end

endmodule

>>> rtl/core/mkds_merge.sv
// Merge stage of the keypad scanner: takes the hit mask of one item and
// emits key codes in column order, at most MAX_EVENTS, through an output
// register. Depends on mkds_pkg.
`timescale 1ns / 1ps

module mkds_merge #(
  parameter int unsigned COLS = mkds_pkg::COLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [COLS-1:0]                  mask_i,
  input  logic [mkds_pkg::CODE_W-1:0]      base_i,
  output logic                             load_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mkds_pkg::CODE_W-1:0]      out_code_o,
  output logic                             out_last_o
);

  localparam int unsigned ColW = (COLS > 1) ? $clog2(COLS) : 1;

  logic                              ev_valid_q, ev_valid_d;
  logic [COLS-1:0]                   ev_mask_q, ev_mask_d;
  logic [mkds_pkg::CODE_W-1:0]       ev_base_q;
  logic [mkds_pkg::EV_CNT_W-1:0]     ev_cnt_q, ev_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [mkds_pkg::CODE_W-1:0]       out_code_q;
  logic                              out_last_q;

  logic [COLS-1:0] pick;
  logic [COLS-1:0] rest;
  logic [ColW-1:0] pick_col;
  logic            pick_last;
  logic            out_adv;
  logic            emit;

  // Isolate the lowest pending column
  assign pick = ev_mask_q & (~ev_mask_q + COLS'(1));
  assign rest = ev_mask_q & ~pick;

  always_comb begin
    pick_col = '0;
    for (int j = 0; j < COLS; j++) begin
      if (pick[j]) begin
        pick_col = pick_col | ColW'(j);
      end
    end
  end

  assign pick_last = (rest == '0) ||
                     (ev_cnt_q == mkds_pkg::EV_CNT_W'(mkds_pkg::MAX_EVENTS - 1));
  assign out_adv   = !out_valid_q || out_ready_i;
  assign emit      = ev_valid_q && out_adv;

  assign load_ready_o = !ev_valid_q || (emit && pick_last);

  // Advance the pending item: a new load replaces a finished one
  always_comb begin
    ev_valid_d = ev_valid_q;
    ev_mask_d  = ev_mask_q;
    ev_cnt_d   = ev_cnt_q;
    if (emit) begin
      ev_mask_d = rest;
      ev_cnt_d  = ev_cnt_q + mkds_pkg::EV_CNT_W'(1);
      if (pick_last) begin
        ev_valid_d = 1'b0;
      end
    end
    if (load_i) begin
      ev_valid_d = 1'b1;
      ev_mask_d  = mask_i;
      ev_cnt_d   = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      ev_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      ev_cnt_q    <= ev_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ev_mask_q <= ev_mask_d;
    if (load_i) begin
      ev_base_q <= base_i;
    end
    if (emit) begin
      out_code_q <= ev_base_q + mkds_pkg::CODE_W'(pick_col);
      out_last_q <= pick_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_pending_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_q |-> (ev_mask_q != '0))
    else $error("pending item with empty mask");

  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $onehot(pick))
    else $error("column pick not one-hot");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> load_ready_o)
    else $error("item loaded while merge stage busy");

  a_load_then_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (ev_valid_q && (ev_cnt_q == '0)))
    else $error("loaded item not pending");
`endif

endmodule

>>> rtl/core/matrix_keypad_debounce_scanner_core.sv
// Top level of the debouncing keypad scanner: config registers, one lane
// per column and the merge stage that emits key codes.
// Depends on mkds_pkg, mkds_lane and mkds_merge.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[1:0] row_index, [5:2] column_bits
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[3:0] key_code, tlast last_event
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Counters of the driven row update in the cycle an item is accepted, one lane
// per column, so items may follow each other in consecutive cycles while the
// merge stage is free, which sets the rate. An item emits at most four key codes
// and holds the merge stage until its last code goes out; no-event items skip it.
// Reset clears all held counters at once and loads the register defaults.
// A stalled output holds the merge stage, which in turn holds the input.

module matrix_keypad_debounce_scanner_core #(
  parameter int unsigned ROWS = mkds_pkg::ROWS_DEF,
  parameter int unsigned COLS = mkds_pkg::COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mkds_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // row_index, column_bits
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mkds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // key_code
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mkds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mkds_pkg::CNT_W-1:0]          cfg_data_i
);

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [4:0]  RowsW5 = 5'(ROWS);
  localparam logic [7:0]  ColsW8 = 8'(COLS);

  logic [mkds_pkg::CNT_W-1:0] threshold_q;
  logic [mkds_pkg::CNT_W-1:0] limit_q;

  logic [mkds_pkg::ROW_IDX_W-1:0] row_index;
  logic [mkds_pkg::SAMPLE_W-1:0]  column_bits;
  logic                           accept;
  logic                           row_ok;
  logic                           upd;
  logic [RowW-1:0]                lane_row;
  logic [7:0]                     base_full;
  logic [COLS-1:0]                hits;
  logic                           load_ready;
  logic [mkds_pkg::CODE_W-1:0]    key_code;

  // Unpack the input item
  assign row_index   = s_axis_tdata[1:0];
  assign column_bits = s_axis_tdata[5:2];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign row_ok   = (5'(row_index) < RowsW5);
  assign upd      = accept && row_ok;
  assign lane_row = RowW'(row_index);
  assign base_full = 8'(row_index) * ColsW8;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= mkds_pkg::PRESS_THRESHOLD_RST;
      limit_q     <= mkds_pkg::COUNT_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mkds_pkg::REG_PRESS_THRESHOLD: threshold_q <= cfg_data_i;
        mkds_pkg::REG_COUNT_LIMIT:     limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One lane per column; columns without a sample bit read low
  for (genvar j = 0; j < COLS; j++) begin : g_lane
    logic high;
    if (j < mkds_pkg::SAMPLE_W) begin : g_sampled
      assign high = column_bits[j];
    end else begin : g_unsampled
      assign high = 1'b0;
    end

    mkds_lane #(
      .ROWS(ROWS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (upd),
      .row_i      (lane_row),
      .high_i     (high),
      .threshold_i(threshold_q),
      .limit_i    (limit_q),
      .hit_o      (hits[j])
    );
  end

  // Merge the lane hits into ordered key codes
  mkds_merge #(
    .COLS(COLS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (upd && (hits != '0)),
    .mask_i      (hits),
    .base_i      (base_full[3:0]),
    .load_ready_o(load_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (key_code),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = load_ready;
  assign m_axis_tdata  = {4'b0000, key_code};

endmodule
